// ===== rtl/feh_pkg.sv =====
// ----------------------------------------------------------------------------
// feh_pkg - fire effect heat map shared definitions
// Map geometry, generator constants, command and register codes.
// ----------------------------------------------------------------------------
package feh_pkg;

  // Map geometry
  localparam int MAP_WIDTH     = 640;
  localparam int MAP_HEIGHT    = 48;
  localparam int CELLS         = MAP_WIDTH * MAP_HEIGHT;
  localparam int XW            = $clog2(MAP_WIDTH);
  localparam int AW            = $clog2(CELLS);
  localparam int SEED_BASE     = (MAP_HEIGHT - 1) * MAP_WIDTH;
  localparam int LAST_ROW_BASE = (MAP_HEIGHT - 2) * MAP_WIDTH;

  // Generator: one step and two chained steps folded together
  localparam logic [31:0] LCG_MUL   = 32'd1103515245;
  localparam logic [31:0] LCG_ADD   = 32'd12345;
  localparam logic [31:0] LCG_MUL2  = 32'(64'(LCG_MUL) * 64'(LCG_MUL));
  localparam logic [31:0] LCG_ADD2  = 32'(64'(LCG_MUL) * 64'(LCG_ADD) + 64'(LCG_ADD));
  localparam logic [31:0] LCG_RESET = 32'hCAFE_F00D;

  // Reciprocal of 100 for 15-bit draws: floor(v * 5243 / 2^19) == v / 100
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int          RECIP_SH  = 19;
  localparam logic [6:0]  PCT_BASE  = 7'd100;

  localparam logic [6:0] IGNITE_RESET = 7'd35;
  localparam logic [7:0] HOT          = 8'd255;

  // Command codes
  typedef enum logic [1:0] {
    KIND_ADVANCE = 2'd0,
    KIND_READ    = 2'd1,
    KIND_RESEED  = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_t;

  // Drift draw codes
  localparam logic [1:0] DRIFT_LEFT  = 2'd0;
  localparam logic [1:0] DRIFT_RIGHT = 2'd2;

  // Register index (paddr[2])
  localparam logic REG_IGNITE = 1'b0;

  // 15-bit value mod 3: base-4 digits each count 1 mod 3
  function automatic logic [1:0] mod3_15(input logic [14:0] v);
    logic [4:0] s;
    logic [2:0] t;
    logic [2:0] u;
    s = {4'b0, v[14]};
    for (int i = 0; i < 7; i++) begin
      s = s + {3'b0, v[2*i +: 2]};
    end
    t = {1'b0, s[1:0]} + {1'b0, s[3:2]} + {2'b0, s[4]};
    u = {1'b0, t[1:0]} + {2'b0, t[2]};
    if (u >= 3'd3) begin
      u = u - 3'd3;
    end
    return u[1:0];
  endfunction

endpackage

// ===== rtl/fire_effect_heat_update.sv =====
// ----------------------------------------------------------------------------
// fire_effect_heat_update - fire effect heat map engine
// Byte heat map in one dual-port RAM, updated by a three-stage
// read/modify/write pipeline driven by a 32-bit LCG.
// ----------------------------------------------------------------------------
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+--------------------------
//  command  | in_kind in_column in_line in_seed       | start, taken when !busy
//  result   | out_heat out_done_kind                  | out_valid, one cycle
//  config   | psel penable pwrite paddr pwdata prdata | APB, pready tied high
//
//  An advance walks the map one cell per cycle, set by the single RAM write
//  port, and pauses for two pipeline drains (after the bottom row and at the
//  end). A clear sweeps the whole map to zero.
//  After reset the RAM is swept to zero with busy high; config writes are
//  taken throughout.
//  Results cannot be stalled: out_valid is a single-cycle strobe.
//
module fire_effect_heat_update
  import feh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // command request
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [9:0]  in_column,
  input  logic [5:0]  in_line,
  input  logic [31:0] in_seed,
  // result
  output logic        out_valid,
  output logic [7:0]  out_heat,
  output logic [1:0]  out_done_kind,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [8:0] {
    ST_INIT      = 9'b000000001,
    ST_IDLE      = 9'b000000010,
    ST_RD_ISSUE  = 9'b000000100,
    ST_RD_WAIT   = 9'b000001000,
    ST_SEED      = 9'b000010000,
    ST_SEED_WAIT = 9'b000100000,
    ST_ROWS      = 9'b001000000,
    ST_ROW_WAIT  = 9'b010000000,
    ST_CLEAR     = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [6:0]    ignite_r;
  logic [31:0]   lcg_r;
  logic [XW-1:0] x_r;
  logic [AW-1:0] row_base_r;
  logic [AW-1:0] clr_addr_r;
  logic [AW-1:0] cmd_addr_r;
  logic          cmd_ok_r;

  logic          out_valid_r;
  logic [7:0]    out_heat_r;
  logic [1:0]    out_done_kind_r;

  // pipeline stage 1
  logic          s1_vld_r;
  logic          s1_seed_r;
  logic [XW-1:0] s1_x_r;
  logic [AW-1:0] s1_base_r;
  logic [14:0]   s1_v1_r;
  logic [14:0]   s1_v2_r;
  // pipeline stage 2
  logic          s2_vld_r;
  logic          s2_seed_r;
  logic [XW-1:0] s2_x_r;
  logic [AW-1:0] s2_base_r;
  logic [14:0]   s2_v1_r;
  logic [8:0]    s2_q_r;
  logic [1:0]    s2_decay_r;
  logic [1:0]    s2_drift_r;
  logic [7:0]    s2_below_r;

  // heat RAM
  logic [7:0]    heat_mem [CELLS];
  logic [7:0]    rd_q_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;

  logic          accept;
  kind_t         kind;
  logic          cfg_wr;
  logic          issue;
  logic          sweep;
  logic          row_end;
  logic          last_row;
  logic          clr_end;
  logic          pipe_empty;
  logic [31:0]   lcg_m1;
  logic [31:0]   lcg_m2;
  logic [27:0]   q_prod;
  logic [14:0]   rem;
  logic [7:0]    seed_heat;
  logic [7:0]    cell_val;
  logic [XW-1:0] dst_x;
  logic [31:0]   rd_lin;
  logic          rd_in_range;

  assign accept     = start && !busy;
  assign kind       = kind_t'(in_kind);
  assign cfg_wr     = psel && penable && pwrite;
  assign issue      = (state_r == ST_SEED) || (state_r == ST_ROWS);
  assign sweep      = (state_r == ST_INIT) || (state_r == ST_CLEAR);
  assign row_end    = (x_r == XW'(MAP_WIDTH - 1));
  assign last_row   = (row_base_r == AW'(LAST_ROW_BASE));
  assign clr_end    = (clr_addr_r == AW'(CELLS - 1));
  assign pipe_empty = !s1_vld_r && !s2_vld_r;

  // generator: one step for seeding/decay, two steps for drift
  assign lcg_m1 = lcg_r * LCG_MUL + LCG_ADD;
  assign lcg_m2 = lcg_r * LCG_MUL2 + LCG_ADD2;

  // read command address and range check
  assign rd_lin      = 32'(in_line) * 32'(MAP_WIDTH) + 32'(in_column);
  assign rd_in_range = (32'(in_column) < 32'(MAP_WIDTH)) &&
                       (32'(in_line) < 32'(MAP_HEIGHT));

  // stage 1 arithmetic: quotient by 100 through the reciprocal
  assign q_prod = 28'(s1_v1_r) * 28'(RECIP_100);

  // stage 2: bottom row ignition
  assign rem       = s2_v1_r - 15'(s2_q_r * PCT_BASE);
  assign seed_heat = (rem[6:0] < ignite_r) ? HOT : 8'd0;

  // stage 2: decayed heat and drifted column
  assign cell_val = (s2_below_r > {6'b0, s2_decay_r}) ?
                    (s2_below_r - {6'b0, s2_decay_r}) : 8'd0;

  always_comb begin
    case (s2_drift_r)
      DRIFT_LEFT: begin
        dst_x = (s2_x_r == '0) ? s2_x_r : (s2_x_r - XW'(1));
      end
      DRIFT_RIGHT: begin
        dst_x = (s2_x_r == XW'(MAP_WIDTH - 1)) ? s2_x_r : (s2_x_r + XW'(1));
      end
      default: begin
        dst_x = s2_x_r;
      end
    endcase
  end

  // RAM port selection
  assign mem_we    = sweep || s2_vld_r;
  assign mem_waddr = sweep ? clr_addr_r :
                     (s2_seed_r ? AW'(s2_base_r + AW'(s2_x_r)) : AW'(s2_base_r + AW'(dst_x)));
  assign mem_wdata = sweep ? 8'd0 : (s2_seed_r ? seed_heat : cell_val);
  assign mem_raddr = (state_r == ST_ROWS) ?
                     AW'(row_base_r + AW'(MAP_WIDTH) + AW'(x_r)) : cmd_addr_r;

  // heat RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      heat_mem[mem_waddr] <= mem_wdata;
    end
    rd_q_r <= heat_mem[mem_raddr];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (clr_end) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_ADVANCE: state_nxt = ST_SEED;
            KIND_READ:    state_nxt = ST_RD_ISSUE;
            KIND_CLEAR:   state_nxt = ST_CLEAR;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RD_ISSUE:  state_nxt = ST_RD_WAIT;
      ST_RD_WAIT:   state_nxt = ST_IDLE;
      ST_SEED: begin
        if (row_end) state_nxt = ST_SEED_WAIT;
      end
      ST_SEED_WAIT: begin
        if (pipe_empty) state_nxt = ST_ROWS;
      end
      ST_ROWS: begin
        if (row_end && last_row) state_nxt = ST_ROW_WAIT;
      end
      ST_ROW_WAIT: begin
        if (pipe_empty) state_nxt = ST_IDLE;
      end
      ST_CLEAR: begin
        if (clr_end) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      lcg_r       <= LCG_RESET;
      ignite_r    <= IGNITE_RESET;
      out_valid_r <= 1'b0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      x_r         <= '0;
      row_base_r  <= '0;
      clr_addr_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      s1_vld_r    <= issue;
      s2_vld_r    <= s1_vld_r;

      // register write
      if (cfg_wr && (paddr[2] == REG_IGNITE)) begin
        ignite_r <= pwdata[6:0];
      end

      // generator advances per issued cell: one step on the bottom row, two in the row pass
      if (issue) begin
        lcg_r <= (state_r == ST_SEED) ? lcg_m1 : lcg_m2;
      end else if (accept && (kind == KIND_RESEED)) begin
        lcg_r <= in_seed;
      end

      // sweep counter
      if (sweep) begin
        clr_addr_r <= clr_end ? '0 : (clr_addr_r + AW'(1));
      end

      // column and row walk
      if (accept && (kind == KIND_ADVANCE)) begin
        x_r        <= '0;
        row_base_r <= '0;
      end else if (issue) begin
        x_r <= row_end ? '0 : (x_r + XW'(1));
        if ((state_r == ST_ROWS) && row_end && !last_row) begin
          row_base_r <= AW'(row_base_r + AW'(MAP_WIDTH));
        end
      end

      // result strobes
      if (accept && (kind == KIND_RESEED)) begin
        out_valid_r <= 1'b1;
      end
      if ((state_r == ST_RD_WAIT) ||
          ((state_r == ST_CLEAR) && clr_end) ||
          ((state_r == ST_ROW_WAIT) && pipe_empty)) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_addr_r <= AW'(rd_lin);
      cmd_ok_r   <= rd_in_range;
      out_done_kind_r <= in_kind;
    end
    if (state_r == ST_RD_WAIT) begin
      out_heat_r <= cmd_ok_r ? rd_q_r : 8'd0;
    end else if (state_r == ST_IDLE) begin
      out_heat_r <= 8'd0;
    end

    // stage 1
    s1_seed_r <= (state_r == ST_SEED);
    s1_x_r    <= x_r;
    s1_base_r <= (state_r == ST_SEED) ? AW'(SEED_BASE) : row_base_r;
    s1_v1_r   <= lcg_m1[30:16];
    s1_v2_r   <= lcg_m2[30:16];

    // stage 2
    s2_seed_r  <= s1_seed_r;
    s2_x_r     <= s1_x_r;
    s2_base_r  <= s1_base_r;
    s2_v1_r    <= s1_v1_r;
    s2_q_r     <= q_prod[RECIP_SH +: 9];
    s2_decay_r <= mod3_15(s1_v1_r);
    s2_drift_r <= mod3_15(s1_v2_r);
    s2_below_r <= rd_q_r;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_heat      = out_heat_r;
  assign out_done_kind = out_done_kind_r;
  assign pready        = 1'b1;
  assign prdata        = (paddr[2] == REG_IGNITE) ? {25'b0, ignite_r} : 32'b0;

`ifndef ASSERT_OFF
  // no RAM write once the block reports idle
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mem_we)
    else $error("heat RAM written while idle");

  // a result is only ever issued with the sequencer back in idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result strobe outside idle");

  // bottom-row writes must land before the row pass reads them
  a_seed_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_vld_r && s2_seed_r) |-> ((state_r == ST_SEED) || (state_r == ST_SEED_WAIT)))
    else $error("seed write overlaps row pass");

  // pipeline only carries work during a frame advance
  a_pipe_in_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> ((state_r == ST_SEED) || (state_r == ST_SEED_WAIT) ||
                  (state_r == ST_ROWS) || (state_r == ST_ROW_WAIT)))
    else $error("pipeline active outside frame advance");
`endif

endmodule
